[rtl/rng_sample_statistical_tester_core_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sample statistical tester
// Shared property forms, each clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RNG_SAMPLE_STATISTICAL_TESTER_CORE_DEFINES_SVH
`define RNG_SAMPLE_STATISTICAL_TESTER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSST_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSST_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/rsst_pkg.sv]
// ----------------------------------------------------------------------------
// rsst_pkg
// Shared widths, register codes, run bounds and types of the sample tester.
// ----------------------------------------------------------------------------
package rsst_pkg;

	// Default sample size in nibbles (20000 bits).
	localparam int SAMPLE_NIBBLES_DEF = 5000;

	// Field widths.
	localparam int NIB_W    = 4;
	localparam int ONES_W   = 15;
	localparam int STAT_W   = 29;
	localparam int DIGIT_W  = 13;
	localparam int SUM_W    = 25;
	localparam int RLEN_W   = 6;
	localparam int RCNT_W   = 14;
	localparam int BUCKETS  = 6;
	localparam int BKT_W    = 3;
	localparam int DIGITS   = 16;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 29;

	localparam logic [CFG_IDX_W-1:0] CFG_ONES_LO  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ONES_HI  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_POKER_LO = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POKER_HI = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_LEN = 3'd4;

	// Register reset values.
	localparam logic [ONES_W-1:0] ONES_LO_RST  = 15'd9654;
	localparam logic [ONES_W-1:0] ONES_HI_RST  = 15'd10346;
	localparam logic [STAT_W-1:0] POKER_LO_RST = 29'd5150;
	localparam logic [STAT_W-1:0] POKER_HI_RST = 29'd288500;
	localparam logic [RLEN_W-1:0] LONG_LEN_RST = 6'd34;

	// Run length saturation and run bucket saturation.
	localparam logic [RLEN_W-1:0] RUN_LEN_MAX = 6'd63;
	localparam logic [RCNT_W:0]   RUN_SAT     = 15'd16383;

	// Offset of the scaled poker statistic.
	localparam logic [STAT_W-1:0] POKER_OFFSET = 29'd25000000;

	// Inclusive bounds of the run buckets: lengths 1 to 5, then 6 or more.
	localparam logic [RCNT_W-1:0] RUN_LO [BUCKETS] = '{
		14'd2267, 14'd1079, 14'd502, 14'd223, 14'd90, 14'd90
	};
	localparam logic [RCNT_W-1:0] RUN_HI [BUCKETS] = '{
		14'd2733, 14'd1421, 14'd748, 14'd402, 14'd223, 14'd223
	};

	// Totals of a finished sample, handed to the verdict stage.
	typedef struct packed {
		logic [ONES_W-1:0] ones;
		logic [SUM_W-1:0]  square_sum;
		logic              long_seen;
		logic              runs_ok;
	} snap_t;

	// Bucket of a closed run of nonzero length.
	function automatic logic [BKT_W-1:0] run_bucket(input logic [RLEN_W-1:0] len);
		if (len >= 6'd6) begin
			return 3'd5;
		end
		return BKT_W'(len - 6'd1);
	endfunction

endpackage

[rtl/rsst_digit_mem.sv]
// ----------------------------------------------------------------------------
// rsst_digit_mem
// Nibble count memory with read-modify-write, forwarding and the running
// sum of squared counts for the poker test.
// ----------------------------------------------------------------------------
module rsst_digit_mem (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [rsst_pkg::NIB_W-1:0] rd_addr,
	input  logic                       s1_valid,
	input  logic                       s1_last,
	input  logic [rsst_pkg::NIB_W-1:0] s1_addr,
	output logic [rsst_pkg::SUM_W-1:0] sum_next
);
	import rsst_pkg::*;

	logic [DIGIT_W-1:0] mem [DIGITS];
	logic [DIGIT_W-1:0] rd_data_s1;
	logic [DIGITS-1:0]  entry_valid_q;
	logic               fwd_en_q;
	logic [NIB_W-1:0]   fwd_addr_q;
	logic [DIGIT_W-1:0] fwd_data_q;
	logic [SUM_W-1:0]   sum_q;
	logic [DIGIT_W-1:0] count_cur;
	logic [DIGIT_W-1:0] count_new;

	// Memory port: read on request, write back from stage one.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
		if (s1_valid) begin
			mem[s1_addr] <= count_new;
		end
	end

	// Current count: entries not written this sample read as zero, and a
	// write at the same edge as our read is forwarded.
	always_comb begin
		if (!entry_valid_q[s1_addr]) begin
			count_cur = '0;
		end else if (fwd_en_q && (fwd_addr_q == s1_addr)) begin
			count_cur = fwd_data_q;
		end else begin
			count_cur = rd_data_s1;
		end
	end

	assign count_new = count_cur + DIGIT_W'(1);
	assign sum_next  = sum_q + {{(SUM_W-DIGIT_W-1){1'b0}}, count_cur, 1'b1};

	// Forwarding register holds the most recent write.
	always_ff @(posedge clk) begin
		fwd_addr_q <= s1_addr;
		fwd_data_q <= count_new;
	end

	// Entry valid bits, forward enable and square sum; valid bits and sum cleared at sample end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			fwd_en_q      <= 1'b0;
			sum_q         <= '0;
		end else begin
			fwd_en_q <= s1_valid;
			if (s1_valid) begin
				if (s1_last) begin
					entry_valid_q <= '0;
					sum_q         <= '0;
				end else begin
					entry_valid_q[s1_addr] <= 1'b1;
					sum_q                  <= sum_next;
				end
			end
		end
	end

endmodule

[rtl/rsst_run_track.sv]
// ----------------------------------------------------------------------------
// rsst_run_track
// Bit level tracking: ones count, run lengths, run buckets and long runs.
// ----------------------------------------------------------------------------
module rsst_run_track (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s1_valid,
	input  logic                        s1_last,
	input  logic [rsst_pkg::NIB_W-1:0]  s1_nibble,
	input  logic [rsst_pkg::RLEN_W-1:0] long_len,
	output logic [rsst_pkg::ONES_W-1:0] ones_next,
	output logic                        long_next,
	output logic                        runs_ok
);
	import rsst_pkg::*;

	logic              run_bit_q;
	logic [RLEN_W-1:0] run_len_q;
	logic              long_q;
	logic [ONES_W-1:0] ones_q;
	logic [RCNT_W-1:0] zcnt_q [BUCKETS];
	logic [RCNT_W-1:0] ocnt_q [BUCKETS];

	logic              run_bit_n;
	logic [RLEN_W-1:0] run_len_n;
	logic              cur_bit;
	logic [BKT_W-1:0]  bkt;
	logic [BKT_W-1:0]  zinc [BUCKETS];
	logic [BKT_W-1:0]  oinc [BUCKETS];
	logic [RCNT_W-1:0] zcnt_n [BUCKETS];
	logic [RCNT_W-1:0] ocnt_n [BUCKETS];
	logic [RCNT_W:0]   zsum;
	logic [RCNT_W:0]   osum;

	// Walk the four bits, most significant first, closing runs into buckets.
	always_comb begin
		run_bit_n = run_bit_q;
		run_len_n = run_len_q;
		long_next = long_q;
		cur_bit   = 1'b0;
		bkt       = '0;
		for (int k = 0; k < BUCKETS; k++) begin
			zinc[k] = '0;
			oinc[k] = '0;
		end
		for (int i = NIB_W - 1; i >= 0; i--) begin
			cur_bit = s1_nibble[i];
			if ((run_len_n != '0) && (cur_bit == run_bit_n)) begin
				if (run_len_n != RUN_LEN_MAX) begin
					run_len_n = run_len_n + RLEN_W'(1);
				end
			end else begin
				if (run_len_n != '0) begin
					bkt = run_bucket(run_len_n);
					if (run_bit_n) begin
						oinc[bkt] = oinc[bkt] + BKT_W'(1);
					end else begin
						zinc[bkt] = zinc[bkt] + BKT_W'(1);
					end
				end
				run_bit_n = cur_bit;
				run_len_n = RLEN_W'(1);
			end
			if (run_len_n >= long_len) begin
				long_next = 1'b1;
			end
		end
		// The open run is counted when the sample ends.
		if (s1_last) begin
			bkt = run_bucket(run_len_n);
			if (run_bit_n) begin
				oinc[bkt] = oinc[bkt] + BKT_W'(1);
			end else begin
				zinc[bkt] = zinc[bkt] + BKT_W'(1);
			end
		end
	end

	assign ones_next = ones_q + ONES_W'(s1_nibble[3]) + ONES_W'(s1_nibble[2])
		+ ONES_W'(s1_nibble[1]) + ONES_W'(s1_nibble[0]);

	// Saturating bucket updates and the run bounds check.
	always_comb begin
		runs_ok = 1'b1;
		zsum    = '0;
		osum    = '0;
		for (int k = 0; k < BUCKETS; k++) begin
			zsum = {1'b0, zcnt_q[k]} + (RCNT_W+1)'(zinc[k]);
			osum = {1'b0, ocnt_q[k]} + (RCNT_W+1)'(oinc[k]);
			zcnt_n[k] = (zsum > RUN_SAT) ? RUN_SAT[RCNT_W-1:0] : zsum[RCNT_W-1:0];
			ocnt_n[k] = (osum > RUN_SAT) ? RUN_SAT[RCNT_W-1:0] : osum[RCNT_W-1:0];
			if ((zcnt_n[k] < RUN_LO[k]) || (zcnt_n[k] > RUN_HI[k])) begin
				runs_ok = 1'b0;
			end
			if ((ocnt_n[k] < RUN_LO[k]) || (ocnt_n[k] > RUN_HI[k])) begin
				runs_ok = 1'b0;
			end
		end
	end

	// State update; everything clears after the last nibble of a sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_bit_q <= 1'b0;
			run_len_q <= '0;
			long_q    <= 1'b0;
			ones_q    <= '0;
			for (int k = 0; k < BUCKETS; k++) begin
				zcnt_q[k] <= '0;
				ocnt_q[k] <= '0;
			end
		end else if (s1_valid) begin
			if (s1_last) begin
				run_bit_q <= 1'b0;
				run_len_q <= '0;
				long_q    <= 1'b0;
				ones_q    <= '0;
				for (int k = 0; k < BUCKETS; k++) begin
					zcnt_q[k] <= '0;
					ocnt_q[k] <= '0;
				end
			end else begin
				run_bit_q <= run_bit_n;
				run_len_q <= run_len_n;
				long_q    <= long_next;
				ones_q    <= ones_next;
				for (int k = 0; k < BUCKETS; k++) begin
					zcnt_q[k] <= zcnt_n[k];
					ocnt_q[k] <= ocnt_n[k];
				end
			end
		end
	end

endmodule

[rtl/rsst_verdict.sv]
// ----------------------------------------------------------------------------
// rsst_verdict
// Forms the poker statistic and the pass flags of a finished sample and
// holds the result in the output register until it is taken.
// ----------------------------------------------------------------------------
module rsst_verdict (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  rsst_pkg::snap_t             snap,
	input  logic [rsst_pkg::ONES_W-1:0] ones_lo,
	input  logic [rsst_pkg::ONES_W-1:0] ones_hi,
	input  logic [rsst_pkg::STAT_W-1:0] poker_lo,
	input  logic [rsst_pkg::STAT_W-1:0] poker_hi,
	input  logic                        out_stall,
	output logic                        out_valid,
	output logic                        busy,
	output logic [rsst_pkg::ONES_W-1:0] ones_total,
	output logic [rsst_pkg::STAT_W-1:0] poker_scaled,
	output logic                        monobit_pass,
	output logic                        poker_pass,
	output logic                        runs_pass,
	output logic                        long_run_pass
);
	import rsst_pkg::*;

	logic              res_valid_s2;
	snap_t             snap_s2;
	logic              out_valid_q;
	logic [STAT_W-1:0] prod;
	logic [STAT_W-1:0] stat;

	// Sample totals captured from stage one.
	always_ff @(posedge clk) begin
		if (load) begin
			snap_s2 <= snap;
		end
	end

	// Scaled poker statistic, clamped at zero.
	assign prod = {snap_s2.square_sum, 4'b0000};
	assign stat = (prod >= POKER_OFFSET) ? (prod - POKER_OFFSET) : '0;

	// Output register payload.
	always_ff @(posedge clk) begin
		if (res_valid_s2) begin
			ones_total    <= snap_s2.ones;
			poker_scaled  <= stat;
			monobit_pass  <= (snap_s2.ones > ones_lo) && (snap_s2.ones < ones_hi);
			poker_pass    <= (stat > poker_lo) && (stat < poker_hi);
			runs_pass     <= snap_s2.runs_ok;
			long_run_pass <= !snap_s2.long_seen;
		end
	end

	// Result valid flags. The output register is always free when stage two
	// holds a result, since only one verdict is in flight at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			res_valid_s2 <= load;
			if (res_valid_s2) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign busy      = res_valid_s2 || out_valid_q;

endmodule

[rtl/rng_sample_statistical_tester_core.sv]
// ----------------------------------------------------------------------------
// rng_sample_statistical_tester_core
// Monobit, poker, runs and long run tester for a random nibble stream.
// ----------------------------------------------------------------------------
// Usage:
// - The input channel (in_valid, in_stall, nibble) takes one nibble per
//   request, bit 3 first in stream order; one each clock unless in_stall.
// - After every SAMPLE_NIBBLES nibbles the output channel (out_valid,
//   out_stall and the result fields) presents one verdict request; no result
//   is given for the other nibbles.
// - After the edge that accepts the last nibble of a sample, the verdict
//   passes through the count memory read stage and the poker subtract
//   stage into the output register, which shows it.
// - Throughput: one nibble per cycle while in_stall is low, set by the
//   read-modify-write of the nibble count memory (a write is forwarded to a
//   read of the same entry in the next cycle).
// - While a verdict waits under out_stall, nibbles keep flowing; only the
//   last nibble of the next sample is held off by in_stall until the verdict
//   has been taken.
// - Reset clears all counters, the count memory valid bits and the output
//   valid flag; configuration registers return to their defaults. No clearing
//   pass is needed. Configuration is written through cfg_write, cfg_index, cfg_data.
// ----------------------------------------------------------------------------
module rng_sample_statistical_tester_core #(
	parameter int SAMPLE_NIBBLES = rsst_pkg::SAMPLE_NIBBLES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [rsst_pkg::NIB_W-1:0]      nibble,
	input  logic                            cfg_write,
	input  logic [rsst_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rsst_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [rsst_pkg::ONES_W-1:0]     ones_total,
	output logic [rsst_pkg::STAT_W-1:0]     poker_scaled,
	output logic                            monobit_pass,
	output logic                            poker_pass,
	output logic                            runs_pass,
	output logic                            long_run_pass
);
	import rsst_pkg::*;

	localparam int IDX_W = $clog2(SAMPLE_NIBBLES);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLE_NIBBLES - 1);

	logic [ONES_W-1:0] ones_lo_q;
	logic [ONES_W-1:0] ones_hi_q;
	logic [STAT_W-1:0] poker_lo_q;
	logic [STAT_W-1:0] poker_hi_q;
	logic [RLEN_W-1:0] long_len_q;

	logic [IDX_W-1:0]  idx_q;
	logic              accept;
	logic              last_in;
	logic              valid_s1;
	logic              last_s1;
	logic [NIB_W-1:0]  nib_s1;
	logic              verdict_busy;
	logic [SUM_W-1:0]  sum_next;
	logic [ONES_W-1:0] ones_next;
	logic              long_next;
	logic              runs_ok;
	snap_t             snap;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ones_lo_q  <= ONES_LO_RST;
			ones_hi_q  <= ONES_HI_RST;
			poker_lo_q <= POKER_LO_RST;
			poker_hi_q <= POKER_HI_RST;
			long_len_q <= LONG_LEN_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_ONES_LO:  ones_lo_q  <= cfg_data[ONES_W-1:0];
				CFG_ONES_HI:  ones_hi_q  <= cfg_data[ONES_W-1:0];
				CFG_POKER_LO: poker_lo_q <= cfg_data[STAT_W-1:0];
				CFG_POKER_HI: poker_hi_q <= cfg_data[STAT_W-1:0];
				CFG_LONG_LEN: long_len_q <= cfg_data[RLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Input handshake: only the closing nibble waits for a pending verdict.
	assign last_in  = (idx_q == IDX_LAST);
	assign in_stall = last_in && ((valid_s1 && last_s1) || verdict_busy);
	assign accept   = in_valid && !in_stall;

	// Nibble index within the sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (accept) begin
			idx_q <= last_in ? '0 : idx_q + IDX_W'(1);
		end
	end

	// Stage one control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			nib_s1  <= nibble;
			last_s1 <= last_in;
		end
	end

	rsst_digit_mem u_digit_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (nibble),
		.s1_valid (valid_s1),
		.s1_last  (last_s1),
		.s1_addr  (nib_s1),
		.sum_next (sum_next)
	);

	rsst_run_track u_run_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_valid  (valid_s1),
		.s1_last   (last_s1),
		.s1_nibble (nib_s1),
		.long_len  (long_len_q),
		.ones_next (ones_next),
		.long_next (long_next),
		.runs_ok   (runs_ok)
	);

	// Totals of the sample that closes in stage one.
	always_comb begin
		snap.ones       = ones_next;
		snap.square_sum = sum_next;
		snap.long_seen  = long_next;
		snap.runs_ok    = runs_ok;
	end

	rsst_verdict u_verdict (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (valid_s1 && last_s1),
		.snap          (snap),
		.ones_lo       (ones_lo_q),
		.ones_hi       (ones_hi_q),
		.poker_lo      (poker_lo_q),
		.poker_hi      (poker_hi_q),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.busy          (verdict_busy),
		.ones_total    (ones_total),
		.poker_scaled  (poker_scaled),
		.monobit_pass  (monobit_pass),
		.poker_pass    (poker_pass),
		.runs_pass     (runs_pass),
		.long_run_pass (long_run_pass)
	);

endmodule

[rtl/rsst_checker.sv]
// ----------------------------------------------------------------------------
// rsst_checker
// Port level checks of the sample tester, bound to the top level.
// ----------------------------------------------------------------------------
`include "rng_sample_statistical_tester_core_defines.svh"

module rsst_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [rsst_pkg::ONES_W-1:0] ones_total,
	input logic [rsst_pkg::STAT_W-1:0] poker_scaled,
	input logic                        monobit_pass,
	input logic                        poker_pass,
	input logic                        runs_pass,
	input logic                        long_run_pass
);

	// Payload of the verdict request as one vector.
	logic [rsst_pkg::ONES_W+rsst_pkg::STAT_W+3:0] res_bits;

	assign res_bits = {ones_total, poker_scaled, monobit_pass, poker_pass,
		runs_pass, long_run_pass};

	// A stalled verdict stays offered with the same totals and flags.
	`RSST_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "verdict dropped")
	`RSST_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(res_bits), "verdict not held")

	// A sample holds at most 20000 ones.
	`RSST_ASSERT_SAME(a_ones_range, out_valid, ones_total <= 15'd20000, "ones total too large")

	// Passing the strict lower bounds needs nonzero statistics.
	`RSST_ASSERT_SAME(a_mono_nonzero, out_valid && monobit_pass, ones_total != '0, "monobit at zero")
	`RSST_ASSERT_SAME(a_poker_nonzero, out_valid && poker_pass, poker_scaled != '0, "poker at zero")

endmodule

bind rng_sample_statistical_tester_core rsst_checker u_rsst_checker (.*);
